@@ design/mtg_pkg.sv @@
// Shared constants, types and functions of the MT19937 generator.
package mtg_pkg;

   // Store geometry
   localparam int unsigned MtN       = 624;
   localparam int unsigned MtM       = 397;
   localparam int unsigned AddrWidth = 10;

   // Recurrence and tempering constants
   localparam logic [31:0] MtMatrix = 32'h9908_b0df;
   localparam logic [31:0] MtUpper  = 32'h8000_0000;
   localparam logic [31:0] MtLower  = 32'h7fff_ffff;
   localparam logic [31:0] MtMult   = 32'd1812433253;
   localparam logic [31:0] MtMaskB  = 32'h9d2c_5680;
   localparam logic [31:0] MtMaskC  = 32'hefc6_0000;

   localparam logic [AddrWidth-1:0] LastAddr = AddrWidth'(MtN - 1);
   localparam logic [AddrWidth-1:0] FullIdx  = AddrWidth'(MtN);
   localparam logic [AddrWidth-1:0] FarStep  = AddrWidth'(MtM);

   typedef logic [31:0]          word_type;
   typedef logic [32:0]          sample_type;
   typedef logic [AddrWidth-1:0] addr_type;

   // Access request from the sequencer to the state store
   typedef struct packed {
      logic     we;
      addr_type waddr;
      word_type wdata;
      logic     re;
      addr_type raddr_a;
      addr_type raddr_b;
   } ram_req_type;

   // One step of the twist recurrence
   function automatic word_type twist_one(word_type hi_src, word_type lo_src,
                                          word_type far_word);
      word_type y;
      word_type v;
      y = (hi_src & MtUpper) | (lo_src & MtLower);
      v = far_word ^ (y >> 1);
      if (y[0]) begin
         v = v ^ MtMatrix;
      end
      return v;
   endfunction

   // Output tempering
   function automatic word_type temper(word_type x);
      word_type y;
      y = x;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & MtMaskB);
      y = y ^ ((y << 15) & MtMaskC);
      y = y ^ (y >> 18);
      return y;
   endfunction

endpackage

@@ design/mtg_if.sv @@
// Valid/ready channel interfaces for the request and response sides.
interface mtg_req_if;
   import mtg_pkg::*;
   logic     valid;
   logic     ready;
   logic     mode;
   word_type seed_value;

   modport source (output valid, output mode, output seed_value, input ready);
   modport sink (input valid, input mode, input seed_value, output ready);
endinterface

interface mtg_rsp_if;
   import mtg_pkg::*;
   logic       valid;
   logic       ready;
   word_type   word;
   sample_type sample;

   modport source (output valid, output word, output sample, input ready);
   modport sink (input valid, input word, input sample, output ready);
endinterface

@@ design/mtg_ram.sv @@
// State store: 624 x 32 words, one write port, two registered read ports.
module mtg_ram (
   input  logic                 clock,
   input  mtg_pkg::ram_req_type ram_req,
   output mtg_pkg::word_type    rd_a,
   output mtg_pkg::word_type    rd_b
);
   import mtg_pkg::*;

   word_type mem [0:MtN-1];
   word_type rd_a_ff;
   word_type rd_b_ff;

   // Write, and read old data on both ports when enabled
   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem[ram_req.waddr] <= ram_req.wdata;
      end
      if (ram_req.re) begin
         rd_a_ff <= mem[ram_req.raddr_a];
         rd_b_ff <= mem[ram_req.raddr_b];
      end
   end

   assign rd_a = rd_a_ff;
   assign rd_b = rd_b_ff;

endmodule

@@ design/mersenne_twister_generator.sv @@
// MT19937 generator top level: sequencer for seeding, twisting and drawing.
//
//   channel   dir   handshake     payload
//   req_bus   in    valid/ready   mode, seed_value
//   rsp_bus   out   valid/ready   word, sample (one per draw, none per seed)
//
// A draw steps through the accepting cycle, a store read, then temper into
// the output register, which waits while the previous response is untaken.
// A draw that finds the index at 624 first twists the store: a prime read
// of word 0, then streaming read-modify-write through the single write
// port of the store. A seed writes word 0 in the accepting cycle and then
// the rest of the store, one multiply per word.
// Reset is synchronous; it clears the index to 624, the store is undefined.
// The request side is taken while a finished response still waits; a second
// draw then holds in the output stage and the request side waits with it.
module mersenne_twister_generator (
   input  logic            clock,
   input  logic            reset,
   mtg_req_if.sink         req_bus,
   mtg_rsp_if.source       rsp_bus
);
   import mtg_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SEED  = 6'b000010,
      ST_PRIME = 6'b000100,
      ST_TWIST = 6'b001000,
      ST_READ  = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   state_type   state_ff, state_in;
   addr_type    read_index_ff, read_index_in;
   addr_type    iss_k_ff, iss_k_in;
   addr_type    dat_k_ff, dat_k_in;
   logic        dat_valid_ff, dat_valid_in;
   logic        dat_prime_ff, dat_prime_in;
   word_type    hi_ff, hi_in;
   word_type    seed_prev_ff, seed_prev_in;
   addr_type    seed_i_ff, seed_i_in;
   logic        rsp_valid_ff, rsp_valid_in;
   word_type    rsp_word_ff, rsp_word_in;

   ram_req_type ram_req;
   word_type    rd_a;
   word_type    rd_b;
   word_type    seed_word;
   addr_type    far_sum;
   addr_type    far_addr;
   addr_type    next_addr;

   mtg_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_a    (rd_a),
      .rd_b    (rd_b)
   );

   // Seed recurrence word for index seed_i_ff
   assign seed_word = word_type'(MtMult * (seed_prev_ff ^ (seed_prev_ff >> 30)))
                    + word_type'(seed_i_ff);

   // Neighbor addresses of the step being issued
   assign next_addr = (iss_k_ff == LastAddr) ? '0 : iss_k_ff + addr_type'(1);
   assign far_sum   = iss_k_ff + FarStep;
   assign far_addr  = (far_sum >= FullIdx) ? far_sum - FullIdx : far_sum;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      read_index_in = read_index_ff;
      iss_k_in      = iss_k_ff;
      dat_k_in      = iss_k_ff;
      dat_valid_in  = 1'b0;
      dat_prime_in  = 1'b0;
      hi_in         = hi_ff;
      seed_prev_in  = seed_prev_ff;
      seed_i_in     = seed_i_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_word_in   = rsp_word_ff;
      ram_req       = '0;
      req_bus.ready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               if (!req_bus.mode) begin
                  // store the seed as word 0, walk the rest
                  ram_req.we    = 1'b1;
                  ram_req.waddr = '0;
                  ram_req.wdata = req_bus.seed_value;
                  seed_prev_in  = req_bus.seed_value;
                  seed_i_in     = addr_type'(1);
                  state_in      = ST_SEED;
               end else if (read_index_ff == FullIdx) begin
                  state_in = ST_PRIME;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_SEED: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = seed_i_ff;
            ram_req.wdata = seed_word;
            seed_prev_in  = seed_word;
            seed_i_in     = seed_i_ff + addr_type'(1);
            if (seed_i_ff == LastAddr) begin
               read_index_in = FullIdx;
               state_in      = ST_IDLE;
            end
         end
         ST_PRIME: begin
            // fetch word 0 as the first upper-bit source
            ram_req.re      = 1'b1;
            ram_req.raddr_a = '0;
            ram_req.raddr_b = '0;
            dat_prime_in    = 1'b1;
            iss_k_in        = '0;
            state_in        = ST_TWIST;
         end
         ST_TWIST: begin
            // issue reads for the next step
            if (iss_k_ff != FullIdx) begin
               ram_req.re      = 1'b1;
               ram_req.raddr_a = next_addr;
               ram_req.raddr_b = far_addr;
               dat_valid_in    = 1'b1;
               iss_k_in        = iss_k_ff + addr_type'(1);
            end
            if (dat_prime_ff) begin
               hi_in = rd_a;
            end
            // retire the step whose data has arrived
            if (dat_valid_ff) begin
               ram_req.we    = 1'b1;
               ram_req.waddr = dat_k_ff;
               ram_req.wdata = twist_one(hi_ff, rd_a, rd_b);
               hi_in         = rd_a;
               if (dat_k_ff == LastAddr) begin
                  read_index_in = '0;
                  state_in      = ST_READ;
               end
            end
         end
         ST_READ: begin
            ram_req.re      = 1'b1;
            ram_req.raddr_a = read_index_ff;
            ram_req.raddr_b = read_index_ff;
            read_index_in   = read_index_ff + addr_type'(1);
            state_in        = ST_OUT;
         end
         ST_OUT: begin
            // hold the fetched word until the output register frees up
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = temper(rd_a);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         read_index_ff <= FullIdx;
         dat_valid_ff  <= 1'b0;
         dat_prime_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         iss_k_ff      <= '0;
         seed_i_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         read_index_ff <= read_index_in;
         dat_valid_ff  <= dat_valid_in;
         dat_prime_ff  <= dat_prime_in;
         rsp_valid_ff  <= rsp_valid_in;
         iss_k_ff      <= iss_k_in;
         seed_i_ff     <= seed_i_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      dat_k_ff     <= dat_k_in;
      hi_ff        <= hi_in;
      seed_prev_ff <= seed_prev_in;
      rsp_word_ff  <= rsp_word_in;
   end

   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.word   = rsp_word_ff;
   assign rsp_bus.sample = {rsp_word_ff, 1'b1};

endmodule

@@ design/mtg_checker.sv @@
// Port-level assertions for the MT19937 generator, bound to the top level.
module mtg_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              req_mode,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input mtg_pkg::word_type   rsp_word,
   input mtg_pkg::sample_type rsp_sample
);
   import mtg_pkg::*;

   // Response stays offered until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   // Sample is the word shifted up with a set low bit whenever a response is offered
   a_sample_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sample[32:1] == rsp_word) && rsp_sample[0])
      else $error("sample does not match word");

   // Nothing offered right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A seed never produces a response
   a_seed_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_mode && !rsp_valid |=> !rsp_valid)
      else $error("seed transaction produced a response");

   // One transaction at a time on the request side
   a_req_single: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken in back-to-back cycles");

endmodule

bind mersenne_twister_generator mtg_checker u_mtg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .req_mode   (req_bus.mode),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_word   (rsp_bus.word),
   .rsp_sample (rsp_bus.sample)
);

@@ test/mersenne_twister_generator_tb_pkg.sv @@
// Transaction codes shared by the generator testbench files.
package mersenne_twister_generator_tb_pkg;

   typedef enum logic {
      ModeSeed = 1'b0,
      ModeDraw = 1'b1
   } mode_code;

endpackage

@@ test/mersenne_twister_generator_chk.sv @@
// Scoreboard for the MT19937 generator: mirrors the state store and checks each draw.
module mersenne_twister_generator_chk
   import mtg_pkg::*;
   import mersenne_twister_generator_tb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic       req_mode,
   input  word_type   req_seed_value,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  word_type   rsp_word,
   input  sample_type rsp_sample,
   output int         draws_pending,
   output int         mismatches
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      word_type   word;
      sample_type sample;
   } draw_value;

   word_type    store_copy [MtN];
   int unsigned draw_pos;
   draw_value   draws_due [$];

   // Fill the mirror store with the multiplier recurrence
   function automatic void fill_from_seed(word_type s);
      word_type prev;
      store_copy[0] = s;
      for (int unsigned i = 1; i < MtN; i++) begin
         prev = store_copy[i - 1];
         store_copy[i] = MtMult * (prev ^ (prev >> 30)) + word_type'(i);
      end
      draw_pos = MtN;
   endfunction

   // Regenerate all words in place, oldest first
   function automatic void regenerate_store();
      word_type joined;
      word_type mixed;
      for (int unsigned k = 0; k < MtN; k++) begin
         joined = (store_copy[k] & MtUpper) | (store_copy[(k + 1) % MtN] & MtLower);
         mixed = store_copy[(k + MtM) % MtN] ^ (joined >> 1);
         if (joined[0]) begin
            mixed = mixed ^ MtMatrix;
         end
         store_copy[k] = mixed;
      end
      draw_pos = 0;
   endfunction

   function automatic word_type scramble_bits(word_type x);
      word_type t;
      t = x ^ (x >> 11);
      t = t ^ ((t << 7) & MtMaskB);
      t = t ^ ((t << 15) & MtMaskC);
      return t ^ (t >> 18);
   endfunction

   // Produce the next tempered word and its 33-bit fraction (2y+1)
   function automatic draw_value next_draw();
      draw_value d;
      if (draw_pos >= MtN) begin
         regenerate_store();
      end
      d.word = scramble_bits(store_copy[draw_pos]);
      draw_pos++;
      d.sample = {d.word, 1'b1};
      return d;
   endfunction

   // Retire the oldest draw on each response, then apply the new request
   always @(posedge clock) begin
      draw_value due;
      if (reset) begin
         draws_due.delete();
         draw_pos = MtN;
         mismatches = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (draws_due.size() == 0) begin
               $error("unexpected response: word %h sample %h", rsp_word, rsp_sample);
               mismatches++;
            end else begin
               due = draws_due.pop_front();
               if (rsp_word !== due.word) begin
                  $error("word: expected %h, got %h", due.word, rsp_word);
                  mismatches++;
               end
               if (rsp_sample !== due.sample) begin
                  $error("sample: expected %h, got %h", due.sample, rsp_sample);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_mode == ModeDraw) begin
               draws_due.push_back(next_draw());
            end else begin
               fill_from_seed(req_seed_value);
            end
         end
      end
      draws_pending <= draws_due.size();
   end

endmodule

@@ test/mersenne_twister_generator_tb.sv @@
// Testbench top for the MT19937 generator: stimulus, flow control and verdict.
module mersenne_twister_generator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mtg_pkg::*;
   import mersenne_twister_generator_tb_pkg::*;

   localparam int unsigned LongRunDraws    = 700;
   localparam int unsigned MixedItems      = 230;
   localparam int unsigned ReadyHoldCycles = 400;
   localparam int unsigned SettleCycles    = 700;
   localparam int unsigned IdleLimit       = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   draws_pending;
   int   mismatches;
   int unsigned sent_items = 0;
   int unsigned idle_cycles = 0;

   mtg_req_if req_bus ();
   mtg_rsp_if rsp_bus ();

   mersenne_twister_generator dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   mersenne_twister_generator_chk draw_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_bus.valid),
      .req_ready      (req_bus.ready),
      .req_mode       (req_bus.mode),
      .req_seed_value (req_bus.seed_value),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_word       (rsp_bus.word),
      .rsp_sample     (rsp_bus.sample),
      .draws_pending  (draws_pending),
      .mismatches     (mismatches)
   );

   always #1 clock = ~clock;

   // Mostly short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 60) return 0;
      if (roll < 88) return $urandom_range(3, 1);
      if (roll < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   // Favor the all-zero and all-one seeds now and then
   function automatic word_type random_seed();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return $urandom();
      endcase
   endfunction

   // Hold the request low for the gap given by n
   task automatic rest(input int unsigned n);
      if (n > 0) begin
         req_bus.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Offer one transaction, wait until it is taken, then mostly rest for a random gap
   task automatic send_item(input mode_code m, input word_type s);
      req_bus.valid <= 1'b1;
      req_bus.mode <= m;
      req_bus.seed_value <= s;
      do @(posedge clock); while (!req_bus.ready);
      sent_items++;
      if ((sent_items / 40) % 4 != 3) begin
         rest(pick_gap());
      end
   endtask

   // Draw with random filler in the unused seed field
   task automatic draw_one();
      send_item(ModeDraw, $urandom());
   endtask

   // Stop offering until every outstanding draw has come back
   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (draws_pending != 0);
   endtask

   // Response side: random back-pressure, steady stretches, one long hold-off
   initial begin : receiver
      int unsigned taken;
      int unsigned hold_left;
      int unsigned gap_left;
      int unsigned cycle_no;
      bit          long_hold_done;
      taken = 0;
      hold_left = 0;
      gap_left = 0;
      cycle_no = 0;
      long_hold_done = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         cycle_no++;
         if (rsp_bus.valid && rsp_bus.ready) begin
            taken++;
         end
         if (!long_hold_done && taken >= 60) begin
            long_hold_done = 1'b1;
            hold_left = ReadyHoldCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if ((cycle_no / 300) % 3 != 2) begin
               gap_left = pick_gap();
            end
         end
      end
   end

   // Abort when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      req_bus.valid <= 1'b0;
      req_bus.mode <= ModeSeed;
      req_bus.seed_value <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extreme seeds, back-to-back reseeding, short draw runs
      send_item(ModeSeed, 32'h0000_0000);
      repeat (3) draw_one();
      send_item(ModeSeed, 32'hffff_ffff);
      repeat (2) draw_one();
      send_item(ModeSeed, 32'hffff_ffff);
      send_item(ModeSeed, 32'd5489);
      repeat (3) draw_one();
      send_item(ModeSeed, 32'h8000_0000);
      draw_one();
      send_item(ModeSeed, 32'h7fff_ffff);
      draw_one();
      send_item(ModeSeed, 32'h0000_0001);
      draw_one();
      drain();

      // Long draw run: crosses two full twist passes
      send_item(ModeSeed, $urandom());
      repeat (LongRunDraws) draw_one();

      // Mixed seeds and draws with random content
      repeat (MixedItems) begin
         if ($urandom_range(99) < 12) begin
            send_item(ModeSeed, random_seed());
         end else begin
            draw_one();
         end
      end
      drain();

      // Let a trailing seed pass finish and catch any stray response
      repeat (SettleCycles) @(posedge clock);
      if (mismatches == 0 && draws_pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
